/* src/cpte_pkg.sv */
// shared types, constants and triangle tables for the cube and plane triangle expander
package cpte_pkg;

  localparam int CoordW   = 24;
  localparam int VertW    = 25;
  localparam int HalfW    = 15;
  localparam int SizeW    = 23;
  localparam int ThirdW   = 22;
  localparam int MatW     = 16;
  localparam int DistW    = 52;
  localparam int TriW     = 4;
  localparam int CfgIdxW  = 8;
  localparam int InDataW  = 104;
  localparam int OutDataW = 296;

  localparam logic [DistW-1:0] DistMax    = '1;
  localparam logic [TriW-1:0]  CubeLast   = 4'd11;
  localparam logic [TriW-1:0]  PlaneLast  = 4'd1;
  localparam logic [15:0]      RecipThree = 16'd43691;
  localparam int               RecipShift = 17;
  localparam logic [ThirdW-1:0] ByteThird = 22'd85;

  typedef enum logic {
    KIND_CUBE  = 1'b0,
    KIND_PLANE = 1'b1
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_DIST = 8'd0,
    REG_CAM_X    = 8'd1,
    REG_CAM_Y    = 8'd2,
    REG_CAM_Z    = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DistW-1:0]         max_dist;
    logic signed [CoordW-1:0] cam_x;
    logic signed [CoordW-1:0] cam_y;
    logic signed [CoordW-1:0] cam_z;
  } cfg_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [HalfW-1:0]         hs;
    logic [MatW-1:0]          mat;
  } item_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [SizeW-1:0]         s;
    logic [ThirdW-1:0]        q;
    logic                     rnz;
    logic [MatW-1:0]          mat;
  } prim_t;

  typedef struct packed {
    logic signed [VertW-1:0] p0_x;
    logic signed [VertW-1:0] p0_y;
    logic signed [VertW-1:0] p0_z;
    logic signed [VertW-1:0] p1_x;
    logic signed [VertW-1:0] p1_y;
    logic signed [VertW-1:0] p1_z;
    logic signed [VertW-1:0] p2_x;
    logic signed [VertW-1:0] p2_y;
    logic signed [VertW-1:0] p2_z;
    logic [MatW-1:0]         mat;
    logic [DistW-1:0]        cen_dist;
    logic                    last;
  } tri_t;

  // corner indices of one triangle, first corner in the low bits
  function automatic logic [8:0] tri_corners(kind_t kind, logic [TriW-1:0] idx);
    logic [8:0] c;
    c = {3'd2, 3'd1, 3'd0};
    if (kind == KIND_PLANE) begin
      case (idx)
        4'd0:    c = {3'd2, 3'd1, 3'd0};
        4'd1:    c = {3'd3, 3'd2, 3'd1};
        default: c = {3'd2, 3'd1, 3'd0};
      endcase
    end else begin
      case (idx)
        4'd0:    c = {3'd2, 3'd1, 3'd0};
        4'd1:    c = {3'd3, 3'd2, 3'd1};
        4'd2:    c = {3'd6, 3'd5, 3'd4};
        4'd3:    c = {3'd7, 3'd6, 3'd5};
        4'd4:    c = {3'd4, 3'd1, 3'd0};
        4'd5:    c = {3'd5, 3'd4, 3'd1};
        4'd6:    c = {3'd6, 3'd3, 3'd2};
        4'd7:    c = {3'd7, 3'd6, 3'd3};
        4'd8:    c = {3'd4, 3'd2, 3'd0};
        4'd9:    c = {3'd6, 3'd4, 3'd2};
        4'd10:   c = {3'd5, 3'd3, 3'd1};
        4'd11:   c = {3'd7, 3'd5, 3'd3};
        default: c = {3'd2, 3'd1, 3'd0};
      endcase
    end
    return c;
  endfunction

endpackage

/* src/cpte_front.sv */
// front end: accepts primitives, culls by centre distance, precomputes size thirds
module cpte_front (
  input  logic            clk,
  input  logic            rst_n,
  input  cpte_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpte_pkg::item_t in_item,
  output logic            push_valid,
  input  logic            push_full,
  output cpte_pkg::prim_t push_data
);

  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  cpte_pkg::item_t s1_item_r, s2_item_r;
  logic signed [cpte_pkg::VertW-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic [48:0] s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [30:0] s2_hsm_r;

  logic signed [cpte_pkg::VertW-1:0] dx, dy, dz;
  logic signed [49:0] px, py, pz;
  logic [30:0] hsm;
  logic [50:0] ctr_dist;
  logic        cull;
  logic        adv;
  logic [13:0] qh;
  logic [cpte_pkg::HalfW-1:0] three_q;

  assign dx  = cpte_pkg::VertW'(in_item.cx) - cpte_pkg::VertW'(cfg.cam_x);
  assign dy  = cpte_pkg::VertW'(in_item.cy) - cpte_pkg::VertW'(cfg.cam_y);
  assign dz  = cpte_pkg::VertW'(in_item.cz) - cpte_pkg::VertW'(cfg.cam_z);

  assign px  = s1_dx_r * s1_dx_r;
  assign py  = s1_dy_r * s1_dy_r;
  assign pz  = s1_dz_r * s1_dz_r;
  assign hsm = 31'(s1_item_r.hs) * 31'(cpte_pkg::RecipThree);

  assign ctr_dist = 51'(s2_sqx_r) + 51'(s2_sqy_r) + 51'(s2_sqz_r);
  assign cull = {1'b0, ctr_dist} > cfg.max_dist;
  assign qh   = s2_hsm_r[cpte_pkg::RecipShift +: 14];
  assign three_q = cpte_pkg::HalfW'({qh, 1'b0}) + cpte_pkg::HalfW'(qh);

  assign adv        = !s2_v_r || cull || !push_full;
  assign in_ready   = adv;
  assign push_valid = s2_v_r && !cull && !push_full;

  always_comb begin
    push_data      = '0;
    push_data.kind = s2_item_r.kind;
    push_data.cx   = s2_item_r.cx;
    push_data.cy   = s2_item_r.cy;
    push_data.cz   = s2_item_r.cz;
    push_data.s    = {s2_item_r.hs, 8'h00};
    push_data.q    = cpte_pkg::ThirdW'(s2_item_r.hs) * cpte_pkg::ByteThird
                     + cpte_pkg::ThirdW'(qh);
    push_data.rnz  = three_q != s2_item_r.hs;
    push_data.mat  = s2_item_r.mat;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    if (adv) begin
      s1_v_nxt = in_valid;
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_item;
      s1_dx_r   <= dx;
      s1_dy_r   <= dy;
      s1_dz_r   <= dz;
      s2_item_r <= s1_item_r;
      s2_sqx_r  <= px[48:0];
      s2_sqy_r  <= py[48:0];
      s2_sqz_r  <= pz[48:0];
      s2_hsm_r  <= hsm;
    end
  end

endmodule

/* src/cpte_queue.sv */
// small primitive queue between front and back end
module cpte_queue #(
  parameter int Depth = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cpte_pkg::prim_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output cpte_pkg::prim_t head
);

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] FullCnt  = CountW'(Depth);

  cpte_pkg::prim_t mem_r [Depth];
  logic [AddrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AddrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CountW-1:0] count_r, count_nxt;

  assign full  = count_r == FullCnt;
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastAddr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastAddr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/cpte_back.sv */
// back end: walks the triangle table, builds vertices and centroid distances
module cpte_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cpte_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  cpte_pkg::prim_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output cpte_pkg::tri_t  out_tri
);

  localparam int VW = cpte_pkg::VertW;

  logic [cpte_pkg::TriW-1:0] tri_r, tri_nxt;
  logic b1_v_r, b1_v_nxt;
  logic b2_v_r, b2_v_nxt;
  logic out_v_r, out_v_nxt;

  cpte_pkg::tri_t b1_tri_r, b2_tri_r, out_tri_r;
  logic signed [VW-1:0] b1_cen_r [3];
  logic [50:0] b2_sq_r [3];

  logic adv, issue, last_now, plane;
  logic [8:0] corners;
  logic signed [VW-1:0] s25, q25, qr25;
  logic signed [VW-1:0] ctr [3];
  logic [2:0] up [3];
  logic signed [VW-1:0] vert [3][3];
  logic signed [VW-1:0] cen [3];
  logic signed [VW:0] diff [3];
  logic signed [51:0] prod [3];
  logic [52:0] dsum;
  cpte_pkg::tri_t tri_now;
  cpte_pkg::tri_t tri_done;

  // trunc((v0 + v1 + v2) / 3) from the corner pattern and the precomputed thirds
  function automatic logic signed [VW-1:0] centroid(
    logic signed [VW-1:0] c, logic signed [VW-1:0] v0, logic signed [VW-1:0] v1,
    logic signed [VW-1:0] v2, logic [2:0] u, logic flat, logic signed [VW-1:0] s,
    logic signed [VW-1:0] q, logic signed [VW-1:0] qr);
    logic signed [VW+1:0] sum;
    logic                 neg;
    logic [1:0]           n;
    logic signed [VW-1:0] off;
    sum = (VW+2)'(v0) + (VW+2)'(v1) + (VW+2)'(v2);
    neg = sum[VW+1];
    n   = 2'(u[0]) + 2'(u[1]) + 2'(u[2]);
    off = '0;
    if (!flat) begin
      case (n)
        2'd0:    off = -s;
        2'd1:    off = neg ? -q : -qr;
        2'd2:    off = neg ? qr : q;
        2'd3:    off = s;
        default: off = '0;
      endcase
    end
    return c + off;
  endfunction

  assign plane    = head.kind == cpte_pkg::KIND_PLANE;
  assign adv      = !out_v_r || out_ready;
  assign issue    = adv && head_valid;
  assign last_now = plane ? (tri_r == cpte_pkg::PlaneLast) : (tri_r == cpte_pkg::CubeLast);
  assign pop      = issue && last_now;
  assign corners  = cpte_pkg::tri_corners(head.kind, tri_r);

  assign s25  = signed'(VW'(head.s));
  assign q25  = signed'(VW'(head.q));
  assign qr25 = q25 + signed'(VW'(head.rnz));
  assign ctr[0] = VW'(head.cx);
  assign ctr[1] = VW'(head.cy);
  assign ctr[2] = VW'(head.cz);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      up[0][j] = plane ? corners[3*j+1] : corners[3*j+2];
      up[1][j] = corners[3*j+1];
      up[2][j] = corners[3*j];
      for (int a = 0; a < 3; a++) begin
        vert[j][a] = up[a][j] ? ctr[a] + s25 : ctr[a] - s25;
      end
      if (plane) begin
        vert[j][1] = ctr[1];
      end
    end
    for (int a = 0; a < 3; a++) begin
      cen[a] = centroid(ctr[a], vert[0][a], vert[1][a], vert[2][a], up[a],
                        plane && (a == 1), s25, q25, qr25);
    end
  end

  always_comb begin
    tri_now      = '0;
    tri_now.p0_x = vert[0][0];
    tri_now.p0_y = vert[0][1];
    tri_now.p0_z = vert[0][2];
    tri_now.p1_x = vert[1][0];
    tri_now.p1_y = vert[1][1];
    tri_now.p1_z = vert[1][2];
    tri_now.p2_x = vert[2][0];
    tri_now.p2_y = vert[2][1];
    tri_now.p2_z = vert[2][2];
    tri_now.mat  = head.mat;
    tri_now.last = last_now;
  end

  assign diff[0] = (VW+1)'(b1_cen_r[0]) - (VW+1)'(cfg.cam_x);
  assign diff[1] = (VW+1)'(b1_cen_r[1]) - (VW+1)'(cfg.cam_y);
  assign diff[2] = (VW+1)'(b1_cen_r[2]) - (VW+1)'(cfg.cam_z);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = diff[a] * diff[a];
    end
  end

  assign dsum = 53'(b2_sq_r[0]) + 53'(b2_sq_r[1]) + 53'(b2_sq_r[2]);

  always_comb begin
    tri_done          = b2_tri_r;
    tri_done.cen_dist = (dsum > 53'(cpte_pkg::DistMax)) ? cpte_pkg::DistMax
                                                        : dsum[cpte_pkg::DistW-1:0];
  end

  always_comb begin
    tri_nxt   = tri_r;
    b1_v_nxt  = b1_v_r;
    b2_v_nxt  = b2_v_r;
    out_v_nxt = out_v_r;
    if (issue) begin
      tri_nxt = last_now ? '0 : tri_r + 1'b1;
    end
    if (adv) begin
      b1_v_nxt  = issue;
      b2_v_nxt  = b1_v_r;
      out_v_nxt = b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_r   <= '0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      tri_r   <= tri_nxt;
      b1_v_r  <= b1_v_nxt;
      b2_v_r  <= b2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_tri_r <= tri_now;
      for (int a = 0; a < 3; a++) begin
        b1_cen_r[a] <= cen[a];
        b2_sq_r[a]  <= prod[a][50:0];
      end
      b2_tri_r  <= b1_tri_r;
      out_tri_r <= tri_done;
    end
  end

  assign out_valid = out_v_r;
  assign out_tri   = out_tri_r;

endmodule

/* src/cube_plane_triangle_expander_unit.sv */
// top level of the cube and plane triangle expander
// a primitive crosses the front stages, the queue and the back-end stages before its first triangle
// one triangle per cycle while out_tready is high: a cube gives 12 triangles, a plane 2, a culled one none
// a 4-entry queue lets new primitives in while the back end is still expanding
// synchronous active-low reset empties all stages, camera to 0, threshold to all ones
module cube_plane_triangle_expander_unit #(
  parameter int QueueDepth = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cpte_pkg::InDataW-1:0]    in_tdata,   // center_x, center_y, center_z, half_size, material_id
  input  logic                            in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cpte_pkg::OutDataW-1:0]   out_tdata,  // p0_x..p2_z, material_out, centroid_sq_distance
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cpte_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cpte_pkg::DistW-1:0]      cfg_data
);

  cpte_pkg::cfg_t  cfg_r, cfg_nxt;
  cpte_pkg::item_t in_item;
  cpte_pkg::prim_t push_data, head;
  cpte_pkg::tri_t  out_tri;
  logic push_valid, full, empty, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cpte_pkg::cfg_reg_t'(cfg_index))
        cpte_pkg::REG_MAX_DIST: cfg_nxt.max_dist = cfg_data;
        cpte_pkg::REG_CAM_X:    cfg_nxt.cam_x    = cfg_data[cpte_pkg::CoordW-1:0];
        cpte_pkg::REG_CAM_Y:    cfg_nxt.cam_y    = cfg_data[cpte_pkg::CoordW-1:0];
        cpte_pkg::REG_CAM_Z:    cfg_nxt.cam_z    = cfg_data[cpte_pkg::CoordW-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_dist <= cpte_pkg::DistMax;
      cfg_r.cam_x    <= '0;
      cfg_r.cam_y    <= '0;
      cfg_r.cam_z    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    in_item      = '0;
    in_item.kind = cpte_pkg::kind_t'(in_tuser);
    in_item.cx   = in_tdata[23:0];
    in_item.cy   = in_tdata[47:24];
    in_item.cz   = in_tdata[71:48];
    in_item.hs   = in_tdata[86:72];
    in_item.mat  = in_tdata[102:87];
  end

  cpte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_full  (full),
    .push_data  (push_data)
  );

  cpte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  cpte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (!empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_tri    (out_tri)
  );

  assign out_tdata = {3'b000, out_tri.cen_dist, out_tri.mat,
                      out_tri.p2_z, out_tri.p2_y, out_tri.p2_x,
                      out_tri.p1_z, out_tri.p1_y, out_tri.p1_x,
                      out_tri.p0_z, out_tri.p0_y, out_tri.p0_x};
  assign out_tlast = out_tri.last;

endmodule

/* src/cpte_checker.sv */
// port-level assertions for the triangle expander and their bind
module cpte_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [cpte_pkg::OutDataW-1:0] out_tdata,
  input logic                          out_tlast
);

  // stalled triangle holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // reset empties the pipe and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("pipe not empty after reset");

  // each axis of a triangle takes at most two corner values
  a_axis_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[24:0] == out_tdata[99:75] || out_tdata[24:0] == out_tdata[174:150] ||
       out_tdata[99:75] == out_tdata[174:150]) &&
      (out_tdata[49:25] == out_tdata[124:100] || out_tdata[49:25] == out_tdata[199:175] ||
       out_tdata[124:100] == out_tdata[199:175]) &&
      (out_tdata[74:50] == out_tdata[149:125] || out_tdata[74:50] == out_tdata[224:200] ||
       out_tdata[149:125] == out_tdata[224:200]))
    else $error("triangle corner mix-up");

  // centroid distance of in-range coordinates stays below 2^51
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[292])
    else $error("centroid distance out of range");

endmodule

bind cube_plane_triangle_expander_unit cpte_checker u_cpte_checker (.*);

/* verif/testbench.sv */
// self-checking testbench for the cube and plane triangle expander, stream and register ports
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Limit = 400000;
  localparam int DrainCycles = 32;
  localparam int MaxGap = 11;
  localparam int CubeTris = 12;
  localparam int PlaneTris = 2;
  localparam int CornersPerTri = 3;
  localparam int OneUnit = 256;
  localparam int BusW = cpte_pkg::OutDataW + 1;
  localparam logic [cpte_pkg::CfgIdxW-1:0] UnusedReg = 8'hA5;
  localparam logic [cpte_pkg::CoordW-1:0] MinCoord = 24'h800000;
  localparam logic [cpte_pkg::CoordW-1:0] MaxCoord = 24'h7FFFFF;
  localparam logic [cpte_pkg::HalfW-1:0] MaxHalf = 15'h7FFF;
  localparam logic [8*CornersPerTri*CubeTris-1:0] CubeOrder =
    "abcbcdefgfghabebefcdgdghacecegbdfdfh";
  localparam logic [8*CornersPerTri*PlaneTris-1:0] PlaneOrder = "abcbcd";

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [cpte_pkg::InDataW-1:0] in_tdata;   // center_x, center_y, center_z, half_size, material_id
  logic in_tuser;                           // kind
  logic out_tvalid;
  logic out_tready;
  logic [cpte_pkg::OutDataW-1:0] out_tdata; // p0_x..p2_z, material_out, centroid_sq_distance
  logic out_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [cpte_pkg::CfgIdxW-1:0] cfg_index;
  logic [cpte_pkg::DistW-1:0] cfg_data;

  logic [cpte_pkg::DistW-1:0] view_limit;
  logic signed [cpte_pkg::CoordW-1:0] cam_x;
  logic signed [cpte_pkg::CoordW-1:0] cam_y;
  logic signed [cpte_pkg::CoordW-1:0] cam_z;
  cpte_pkg::tri_t tri_queue[$];
  int fail_count = 0;
  int cycle_count = 0;
  int hold_request = 0;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  string field_name[12] = '{"p0_x", "p0_y", "p0_z", "p1_x", "p1_y", "p1_z",
                            "p2_x", "p2_y", "p2_z", "material_out",
                            "centroid_sq_distance", "last_triangle"};

  cube_plane_triangle_expander_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= Limit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [cpte_pkg::DistW-1:0] sq_between(input longint x, input longint y,
                                                            input longint z, input longint ax,
                                                            input longint ay, input longint az);
    longint dx, dy, dz;
    logic [63:0] sum;
    dx = x - ax;
    dy = y - ay;
    dz = z - az;
    sum = dx * dx + dy * dy + dz * dz;
    if (sum > cpte_pkg::DistMax) return cpte_pkg::DistMax;
    return sum[cpte_pkg::DistW-1:0];
  endfunction

  function automatic logic [BusW-1:0] tri_bus(input cpte_pkg::tri_t t);
    return {t.last, 3'b000, t.cen_dist, t.mat, t.p2_z, t.p2_y, t.p2_x,
            t.p1_z, t.p1_y, t.p1_x, t.p0_z, t.p0_y, t.p0_x};
  endfunction

  function automatic cpte_pkg::item_t make_item(input cpte_pkg::kind_t kind, input int x,
                                                input int y, input int z, input int hs,
                                                input int mat);
    cpte_pkg::item_t p;
    p.kind = kind;
    p.cx = x[cpte_pkg::CoordW-1:0];
    p.cy = y[cpte_pkg::CoordW-1:0];
    p.cz = z[cpte_pkg::CoordW-1:0];
    p.hs = hs[cpte_pkg::HalfW-1:0];
    p.mat = mat[cpte_pkg::MatW-1:0];
    return p;
  endfunction

  function automatic logic [cpte_pkg::CoordW-1:0] rand_coord();
    int v;
    if ($urandom_range(0, 3) == 0) v = $urandom;
    else v = $urandom_range(0, 131071) - 65536;
    return v[cpte_pkg::CoordW-1:0];
  endfunction

  function automatic cpte_pkg::item_t rand_item();
    int hs;
    if ($urandom_range(0, 3) == 0) hs = $urandom_range(0, 32767);
    else hs = $urandom_range(0, 300);
    return make_item(cpte_pkg::kind_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                     rand_coord(), hs, $urandom_range(0, 65535));
  endfunction

  // triangles of one primitive, in emission order
  task automatic predict_triangles(input cpte_pkg::item_t p);
    longint s, sx, sy, sz;
    longint vx[8], vy[8], vz[8];
    longint tx[3], ty[3], tz[3];
    logic [8*CornersPerTri*CubeTris-1:0] order;
    logic [7:0] ch;
    int ntri, c, k, i;
    cpte_pkg::tri_t t;
    if (sq_between(p.cx, p.cy, p.cz, cam_x, cam_y, cam_z) > view_limit) return;
    s = p.hs;
    s = s * OneUnit;
    for (c = 0; c < 8; c++) begin
      if (p.kind == cpte_pkg::KIND_PLANE) begin
        vx[c] = c[1] ? p.cx + s : p.cx - s;
        vy[c] = p.cy;
        vz[c] = c[0] ? p.cz + s : p.cz - s;
      end else begin
        vx[c] = c[2] ? p.cx + s : p.cx - s;
        vy[c] = c[1] ? p.cy + s : p.cy - s;
        vz[c] = c[0] ? p.cz + s : p.cz - s;
      end
    end
    if (p.kind == cpte_pkg::KIND_PLANE) begin
      order = PlaneOrder;
      ntri = PlaneTris;
    end else begin
      order = CubeOrder;
      ntri = CubeTris;
    end
    for (k = 0; k < ntri; k++) begin
      for (i = 0; i < CornersPerTri; i++) begin
        ch = order[8 * (CornersPerTri * ntri - 1 - (CornersPerTri * k + i)) +: 8];
        c = ch - "a";
        tx[i] = vx[c];
        ty[i] = vy[c];
        tz[i] = vz[c];
      end
      t.p0_x = tx[0][cpte_pkg::VertW-1:0];
      t.p0_y = ty[0][cpte_pkg::VertW-1:0];
      t.p0_z = tz[0][cpte_pkg::VertW-1:0];
      t.p1_x = tx[1][cpte_pkg::VertW-1:0];
      t.p1_y = ty[1][cpte_pkg::VertW-1:0];
      t.p1_z = tz[1][cpte_pkg::VertW-1:0];
      t.p2_x = tx[2][cpte_pkg::VertW-1:0];
      t.p2_y = ty[2][cpte_pkg::VertW-1:0];
      t.p2_z = tz[2][cpte_pkg::VertW-1:0];
      sx = tx[0] + tx[1] + tx[2];
      sy = ty[0] + ty[1] + ty[2];
      sz = tz[0] + tz[1] + tz[2];
      t.mat = p.mat;
      t.cen_dist = sq_between(sx / CornersPerTri, sy / CornersPerTri, sz / CornersPerTri,
                              cam_x, cam_y, cam_z);
      t.last = (k == ntri - 1);
      tri_queue.push_back(t);
    end
  endtask

  task automatic check_triangle(input logic [BusW-1:0] got);
    cpte_pkg::tri_t want;
    logic [BusW-1:0] exp_bus, se, sg;
    logic [cpte_pkg::DistW-1:0] mask, e, a;
    int k, lo, w;
    if (tri_queue.size() == 0) begin
      fail_count++;
      $display("%0t unexpected item: expected none, actual %h", $time, got);
      return;
    end
    want = tri_queue.pop_front();
    exp_bus = tri_bus(want);
    for (k = 0; k < 12; k++) begin
      lo = (k < 9) ? cpte_pkg::VertW * k
                   : (k == 9 ? 225 : (k == 10 ? 241 : cpte_pkg::OutDataW));
      w = (k < 9) ? cpte_pkg::VertW
                  : (k == 9 ? cpte_pkg::MatW : (k == 10 ? cpte_pkg::DistW : 1));
      mask = (52'd1 << w) - 52'd1;
      se = exp_bus >> lo;
      sg = got >> lo;
      e = se[cpte_pkg::DistW-1:0] & mask;
      a = sg[cpte_pkg::DistW-1:0] & mask;
      if (e !== a) begin
        fail_count++;
        $display("%0t mismatch %s: expected %0h actual %0h", $time, field_name[k], e, a);
      end
    end
  endtask

  // result side
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = receiver_idle ? $urandom_range(0, MaxGap) : 0;
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_triangle({out_tlast, out_tdata});
    end
  end

  task automatic send_primitive(input cpte_pkg::item_t p);
    int gap;
    gap = sender_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, p.mat, p.hs, p.cz, p.cy, p.cx};
    in_tuser <= p.kind;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_triangles(p);
  endtask

  // culled items may still be in flight after the last triangle
  task automatic drain_block();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tri_queue.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cpte_pkg::CfgIdxW-1:0] idx,
                           input logic [cpte_pkg::DistW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      cpte_pkg::REG_MAX_DIST: view_limit = value;
      cpte_pkg::REG_CAM_X:    cam_x = value[cpte_pkg::CoordW-1:0];
      cpte_pkg::REG_CAM_Y:    cam_y = value[cpte_pkg::CoordW-1:0];
      cpte_pkg::REG_CAM_Z:    cam_z = value[cpte_pkg::CoordW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [cpte_pkg::DistW-1:0] limit,
                          input logic [cpte_pkg::CoordW-1:0] x,
                          input logic [cpte_pkg::CoordW-1:0] y,
                          input logic [cpte_pkg::CoordW-1:0] z);
    logic [31:0] r;
    write_reg(cpte_pkg::REG_MAX_DIST, limit);
    r = $urandom;
    write_reg(cpte_pkg::REG_CAM_X, {r[cpte_pkg::DistW-cpte_pkg::CoordW-1:0], x});
    r = $urandom;
    write_reg(cpte_pkg::REG_CAM_Y, {r[cpte_pkg::DistW-cpte_pkg::CoordW-1:0], y});
    r = $urandom;
    write_reg(cpte_pkg::REG_CAM_Z, {r[cpte_pkg::DistW-cpte_pkg::CoordW-1:0], z});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_field_extremes();
    // reset view: no culling, camera at the origin
    send_primitive(make_item(cpte_pkg::KIND_CUBE, MinCoord, MinCoord, MinCoord, 0, 0));
    send_primitive(make_item(cpte_pkg::KIND_CUBE, MaxCoord, MaxCoord, MaxCoord, MaxHalf,
                             16'hFFFF));
    send_primitive(make_item(cpte_pkg::KIND_CUBE, MinCoord, MinCoord, MinCoord, MaxHalf,
                             16'h0001));
    send_primitive(make_item(cpte_pkg::KIND_PLANE, MaxCoord, MaxCoord, MaxCoord, MaxHalf,
                             16'h5A5A));
    send_primitive(make_item(cpte_pkg::KIND_PLANE, MinCoord, MinCoord, MinCoord, 0,
                             16'hA5A5));
    send_primitive(make_item(cpte_pkg::KIND_CUBE, 0, 0, 0, 1, 16'h8000));
    send_primitive(make_item(cpte_pkg::KIND_PLANE, -1, 1, -1, 100, 16'h7FFF));
    send_primitive(make_item(cpte_pkg::KIND_CUBE, 1, -2, 5, 3, 16'h1234));
    drain_block();
    set_view(cpte_pkg::DistMax, MaxCoord, MinCoord, MaxCoord);
    send_primitive(make_item(cpte_pkg::KIND_CUBE, MinCoord, MaxCoord, MinCoord, MaxHalf,
                             16'hFFFF));
    send_primitive(make_item(cpte_pkg::KIND_PLANE, MinCoord, MaxCoord, MinCoord, MaxHalf, 0));
    drain_block();
  endtask

  task automatic test_cull_boundary();
    int ax, ay, az;
    logic [cpte_pkg::DistW-1:0] lim;
    ax = -3000;
    ay = 1234;
    az = 77;
    lim = sq_between(ax + 5000, ay, az, ax, ay, az);
    // an unknown index must leave every register alone
    write_reg(UnusedReg, cpte_pkg::DistW'({$urandom, $urandom}));
    set_view(lim, ax[cpte_pkg::CoordW-1:0], ay[cpte_pkg::CoordW-1:0],
             az[cpte_pkg::CoordW-1:0]);
    send_primitive(make_item(cpte_pkg::KIND_PLANE, ax + 5000, ay, az, 2, 16'h0011));
    send_primitive(make_item(cpte_pkg::KIND_CUBE, ax + 5001, ay, az, 2, 16'h0022));
    send_primitive(make_item(cpte_pkg::KIND_CUBE, ax + 4999, ay, az, 0, 16'h0033));
    send_primitive(make_item(cpte_pkg::KIND_CUBE, ax - 3000, ay + 4000, az, 9, 16'h0044));
    send_primitive(make_item(cpte_pkg::KIND_PLANE, ax - 3000, ay + 4001, az, 9, 16'h0055));
    drain_block();
    set_view('0, ax[cpte_pkg::CoordW-1:0], ay[cpte_pkg::CoordW-1:0],
             az[cpte_pkg::CoordW-1:0]);
    send_primitive(make_item(cpte_pkg::KIND_CUBE, ax, ay, az, 40, 16'h0066));
    send_primitive(make_item(cpte_pkg::KIND_PLANE, ax, ay, az + 1, 40, 16'h0077));
    send_primitive(make_item(cpte_pkg::KIND_PLANE, ax, ay, az, 0, 16'h0088));
    drain_block();
  endtask

  task automatic test_random_traffic();
    int phase, n;
    logic [cpte_pkg::DistW-1:0] lim;
    logic [cpte_pkg::CoordW-1:0] x, y, z;
    for (phase = 0; phase < 6; phase++) begin
      drain_block();
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
      case (phase % 3)
        0: lim = cpte_pkg::DistMax;
        1: lim = sq_between($signed(rand_coord()), $signed(rand_coord()),
                            $signed(rand_coord()), $signed(x), $signed(y), $signed(z));
        default: lim = cpte_pkg::DistW'({$urandom, $urandom});
      endcase
      set_view(lim, x, y, z);
      sender_idle = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      receiver_idle = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      for (n = 0; n < 70; n++) send_primitive(rand_item());
    end
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int n;
    drain_block();
    set_view(cpte_pkg::DistMax, '0, '0, '0);
    sender_idle = 1'b0;
    hold_request = 400;
    for (n = 0; n < 16; n++) begin
      send_primitive(make_item(cpte_pkg::KIND_CUBE, rand_coord(), rand_coord(), rand_coord(),
                               $urandom_range(0, 32767), $urandom_range(0, 65535)));
    end
    sender_idle = 1'b1;
  endtask

  task automatic test_sender_pause();
    int n;
    for (n = 0; n < 15; n++) send_primitive(rand_item());
    drain_block();
    for (n = 0; n < 15; n++) send_primitive(rand_item());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    view_limit = cpte_pkg::DistMax;
    cam_x = '0;
    cam_y = '0;
    cam_z = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_cull_boundary();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    drain_block();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
